// ===== sv/dlts_pkg.sv =====
// Shared types and codes for the delta-list timer scheduler.
// Holds operation, status and result codes, the controller state and command types.
// No dependencies; used by every module of the block.
package dlts_pkg;

  // default sizing handed to the top level
  localparam int TIMER_COUNT_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int TIMERS_RST      = 16;

  // port widths fixed by the interface
  localparam int ACT_W  = 2;
  localparam int ID_W   = 6;
  localparam int RID_W  = 4;
  localparam int STS_W  = 3;
  localparam int CFG_W  = 5;
  localparam int TIN_W  = 32;

  // input item actions
  localparam logic [ACT_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_ZERO_TIME = 3'd1;
  localparam logic [STS_W-1:0] STS_NO_FREE   = 3'd2;
  localparam logic [STS_W-1:0] STS_RANGE     = 3'd3;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd4;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CREATE,
    S_INS_START,
    S_INS_WALK,
    S_INS_NEXT,
    S_C_EMIT,
    S_DEL,
    S_DEL_WALK,
    S_DEL_REM,
    S_DEL_REM2,
    S_TICK,
    S_T_ACT,
    S_T_EMIT
  } state_e;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CREATE,
    OP_INS_START,
    OP_INS_WALK,
    OP_INS_NEXT,
    OP_C_EMIT,
    OP_DEL_CHECK,
    OP_DEL_WALK,
    OP_DEL_REM,
    OP_DEL_REM2,
    OP_TICK,
    OP_T_ACT,
    OP_T_EMIT
  } op_e;

  // datapath status back to the controller
  typedef struct packed {
    logic create_fail;
    logic ins_done;
    logic del_stop;
    logic dw_found;
    logic dw_remove;
    logic dw_miss;
    logic expire;
    logic t_periodic;
    logic t_last;
  } stat_t;

  // one result beat
  typedef struct packed {
    logic [1:0]       kind;
    logic [RID_W-1:0] rid;
    logic [STS_W-1:0] status;
    logic             last;
  } res_t;

endpackage

// ===== sv/dlts_ctrl.sv =====
// Sequencer of the delta-list timer scheduler.
// Walks create, delete and tick items through datapath commands.
// Depends on dlts_pkg.
module dlts_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic [dlts_pkg::ACT_W-1:0] action_i,
  input  dlts_pkg::stat_t            stat_i,
  output dlts_pkg::op_e              op_o,
  output logic                       busy
);

  dlts_pkg::state_e state_q, state_d;
  logic             tick_q, tick_d;
  dlts_pkg::state_e ins_exit;

  // insert returns to the item that called it
  assign ins_exit = tick_q ? dlts_pkg::S_T_EMIT : dlts_pkg::S_C_EMIT;

  // next state
  always_comb begin
    state_d = state_q;
    tick_d  = tick_q;
    case (state_q)
      dlts_pkg::S_IDLE: begin
        if (start) begin
          case (action_i)
            dlts_pkg::ACT_CREATE: begin
              state_d = dlts_pkg::S_CREATE;
              tick_d  = 1'b0;
            end
            dlts_pkg::ACT_DELETE: state_d = dlts_pkg::S_DEL;
            dlts_pkg::ACT_TICK:   state_d = dlts_pkg::S_TICK;
            default: ;
          endcase
        end
      end
      dlts_pkg::S_CREATE:
        state_d = stat_i.create_fail ? dlts_pkg::S_IDLE : dlts_pkg::S_INS_START;
      dlts_pkg::S_INS_START:
        state_d = stat_i.ins_done ? ins_exit : dlts_pkg::S_INS_WALK;
      dlts_pkg::S_INS_WALK:
        state_d = stat_i.ins_done ? ins_exit : dlts_pkg::S_INS_NEXT;
      dlts_pkg::S_INS_NEXT:
        state_d = stat_i.ins_done ? ins_exit : dlts_pkg::S_INS_WALK;
      dlts_pkg::S_C_EMIT: state_d = dlts_pkg::S_IDLE;
      dlts_pkg::S_DEL:
        state_d = stat_i.del_stop ? dlts_pkg::S_IDLE : dlts_pkg::S_DEL_WALK;
      dlts_pkg::S_DEL_WALK: begin
        if (stat_i.dw_remove) begin
          state_d = dlts_pkg::S_DEL_REM;
        end else if (stat_i.dw_found || stat_i.dw_miss) begin
          state_d = dlts_pkg::S_IDLE;
        end
      end
      dlts_pkg::S_DEL_REM:  state_d = dlts_pkg::S_DEL_REM2;
      dlts_pkg::S_DEL_REM2: state_d = dlts_pkg::S_IDLE;
      dlts_pkg::S_TICK:
        state_d = stat_i.expire ? dlts_pkg::S_T_ACT : dlts_pkg::S_IDLE;
      dlts_pkg::S_T_ACT: begin
        if (stat_i.t_periodic) begin
          tick_d  = 1'b1;
          state_d = dlts_pkg::S_INS_START;
        end else if (stat_i.t_last) begin
          state_d = dlts_pkg::S_IDLE;
        end
      end
      dlts_pkg::S_T_EMIT:
        state_d = stat_i.t_last ? dlts_pkg::S_IDLE : dlts_pkg::S_T_ACT;
      default: state_d = dlts_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    op_o = dlts_pkg::OP_NONE;
    case (state_q)
      dlts_pkg::S_IDLE:      op_o = start ? dlts_pkg::OP_LOAD : dlts_pkg::OP_NONE;
      dlts_pkg::S_CREATE:    op_o = dlts_pkg::OP_CREATE;
      dlts_pkg::S_INS_START: op_o = dlts_pkg::OP_INS_START;
      dlts_pkg::S_INS_WALK:  op_o = dlts_pkg::OP_INS_WALK;
      dlts_pkg::S_INS_NEXT:  op_o = dlts_pkg::OP_INS_NEXT;
      dlts_pkg::S_C_EMIT:    op_o = dlts_pkg::OP_C_EMIT;
      dlts_pkg::S_DEL:       op_o = dlts_pkg::OP_DEL_CHECK;
      dlts_pkg::S_DEL_WALK:  op_o = dlts_pkg::OP_DEL_WALK;
      dlts_pkg::S_DEL_REM:   op_o = dlts_pkg::OP_DEL_REM;
      dlts_pkg::S_DEL_REM2:  op_o = dlts_pkg::OP_DEL_REM2;
      dlts_pkg::S_TICK:      op_o = dlts_pkg::OP_TICK;
      dlts_pkg::S_T_ACT:     op_o = dlts_pkg::OP_T_ACT;
      dlts_pkg::S_T_EMIT:    op_o = dlts_pkg::OP_T_EMIT;
      default:               op_o = dlts_pkg::OP_NONE;
    endcase
  end

  assign busy = (state_q != dlts_pkg::S_IDLE);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlts_pkg::S_IDLE;
      tick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
    end
  end

  // a create beat always enters the create check
  a_create_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlts_pkg::S_IDLE && start && action_i == dlts_pkg::ACT_CREATE)
      |=> (state_q == dlts_pkg::S_CREATE))
    else $error("create beat did not enter create check");

  // an insert finished for an expiry goes on with the expiry chain
  a_tick_return : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q && state_q == dlts_pkg::S_INS_WALK && stat_i.ins_done)
      |=> (state_q == dlts_pkg::S_T_EMIT))
    else $error("re-insert did not return to expiry chain");

endmodule

// ===== sv/dlts_datapath.sv =====
// Datapath of the delta-list timer scheduler: slot and timer tables, list heads,
// countdown and the registered result beat. Executes one command per cycle.
// Depends on dlts_pkg.
module dlts_datapath #(
  parameter int TimerCount = dlts_pkg::TIMER_COUNT_DEF,
  parameter int TimeBits   = dlts_pkg::TIME_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dlts_pkg::op_e              op_i,
  input  logic [dlts_pkg::TIN_W-1:0] start_time_i,
  input  logic [dlts_pkg::TIN_W-1:0] cycle_time_i,
  input  logic [dlts_pkg::ID_W-1:0]  timer_id_i,
  input  logic                       cfg_we_i,
  input  logic [dlts_pkg::CFG_W-1:0] cfg_wdata_i,
  output dlts_pkg::stat_t            stat_o,
  output logic                       result_valid_o,
  output dlts_pkg::res_t             res_o
);

  localparam int IW = (TimerCount > 1) ? $clog2(TimerCount) : 1;
  localparam int LW = $clog2(TimerCount + 1);
  localparam int TW = TimeBits;
  localparam logic [LW-1:0] Nil = LW'(TimerCount);
  localparam int AvailRst = (dlts_pkg::TIMERS_RST < TimerCount) ?
                            dlts_pkg::TIMERS_RST : TimerCount;

  // tables
  logic [TW-1:0] slot_delta_q [TimerCount];
  logic [TW-1:0] slot_delta_d [TimerCount];
  logic [LW-1:0] slot_link_q  [TimerCount];
  logic [LW-1:0] slot_link_d  [TimerCount];
  logic [IW-1:0] slot_first_q [TimerCount];
  logic [IW-1:0] slot_first_d [TimerCount];
  logic [IW-1:0] slot_last_q  [TimerCount];
  logic [IW-1:0] slot_last_d  [TimerCount];
  logic [LW-1:0] act_link_q   [TimerCount];
  logic [LW-1:0] act_link_d   [TimerCount];
  logic [TW-1:0] act_period_q [TimerCount];
  logic [TW-1:0] act_period_d [TimerCount];

  // list heads and countdown
  logic [LW-1:0] head_q, head_d, free_slot_q, free_slot_d, free_act_q, free_act_d;
  logic [LW-1:0] avail_q, avail_d;
  logic [TW-1:0] countdown_q, countdown_d;

  // working registers
  logic [TW-1:0]            st_q, st_d, cyc_q, cyc_d, dt_q, dt_d, dtx_q, dtx_d;
  logic [TW-1:0]            tmp_q, tmp_d;
  logic [dlts_pkg::ID_W-1:0] id_q, id_d;
  logic [LW-1:0] tx_q, tx_d, nx_q, nx_d, a_q, a_d, prev_q, prev_d;
  logic [LW-1:0] s_q, s_d, ps_q, ps_d, chain_q, chain_d;

  // result beat
  logic           rvalid_q, rvalid_d;
  dlts_pkg::res_t res_q, res_d;

  // read side
  logic [IW-1:0] tx_i, nx_i, a_i, prev_i, s_i, ps_i, fs_i, fa_i, head_i;
  logic [TW-1:0] sel_time, nx_delta, walk_sum, nh_delta, rem_sum;
  logic [LW-1:0] a_link, fa_link, fs_link, tx_link, s_link, head_link;
  logic [TW-1:0] a_period;
  logic [LW-1:0] cfg_avail;
  logic          id_hit;

  assign tx_i   = tx_q[IW-1:0];
  assign nx_i   = nx_q[IW-1:0];
  assign a_i    = a_q[IW-1:0];
  assign prev_i = prev_q[IW-1:0];
  assign s_i    = s_q[IW-1:0];
  assign ps_i   = ps_q[IW-1:0];
  assign fs_i   = free_slot_q[IW-1:0];
  assign fa_i   = free_act_q[IW-1:0];
  assign head_i = head_q[IW-1:0];

  assign sel_time  = (st_q != '0) ? st_q : cyc_q;
  assign nx_delta  = slot_delta_q[nx_i];
  assign walk_sum  = dtx_q + nx_delta;
  assign rem_sum   = nx_delta + tmp_q;
  assign a_link    = act_link_q[a_i];
  assign a_period  = act_period_q[a_i];
  assign fa_link   = act_link_q[fa_i];
  assign fs_link   = slot_link_q[fs_i];
  assign tx_link   = slot_link_q[tx_i];
  assign s_link    = slot_link_q[s_i];
  assign head_link = slot_link_q[head_i];
  assign nh_delta  = slot_delta_q[head_link[IW-1:0]];
  assign id_hit    = (a_q != Nil) && (32'(a_q) == 32'(id_q));
  assign cfg_avail = (32'(cfg_wdata_i) < 32'(TimerCount)) ? LW'(cfg_wdata_i) : Nil;

  // status to the controller
  always_comb begin
    stat_o = '0;
    stat_o.create_fail = (sel_time == '0) || (free_act_q == Nil);
    case (op_i)
      dlts_pkg::OP_INS_START: stat_o.ins_done = (head_q == Nil);
      dlts_pkg::OP_INS_WALK:  stat_o.ins_done = !(dt_q > dtx_q);
      dlts_pkg::OP_INS_NEXT:  stat_o.ins_done = (nx_q == Nil) || (dt_q < walk_sum);
      default:                stat_o.ins_done = 1'b0;
    endcase
    stat_o.del_stop   = (32'(id_q) >= 32'(avail_q)) || (head_q == Nil);
    stat_o.dw_found   = id_hit;
    stat_o.dw_remove  = id_hit && (prev_q == Nil) && (a_link == Nil);
    stat_o.dw_miss    = (a_q == Nil) && (s_link == Nil);
    stat_o.expire     = (countdown_q == TW'(1)) && (head_q != Nil);
    stat_o.t_periodic = (a_period != '0);
    stat_o.t_last     = (op_i == dlts_pkg::OP_T_EMIT) ? (chain_q == Nil) : (a_link == Nil);
  end

  // command execution
  always_comb begin
    slot_delta_d = slot_delta_q;
    slot_link_d  = slot_link_q;
    slot_first_d = slot_first_q;
    slot_last_d  = slot_last_q;
    act_link_d   = act_link_q;
    act_period_d = act_period_q;
    head_d       = head_q;
    free_slot_d  = free_slot_q;
    free_act_d   = free_act_q;
    avail_d      = avail_q;
    countdown_d  = countdown_q;
    st_d    = st_q;
    cyc_d   = cyc_q;
    dt_d    = dt_q;
    dtx_d   = dtx_q;
    tmp_d   = tmp_q;
    id_d    = id_q;
    tx_d    = tx_q;
    nx_d    = nx_q;
    a_d     = a_q;
    prev_d  = prev_q;
    s_d     = s_q;
    ps_d    = ps_q;
    chain_d = chain_q;
    rvalid_d = 1'b0;
    res_d    = res_q;

    case (op_i)
      // capture the accepted beat
      dlts_pkg::OP_LOAD: begin
        st_d  = TW'(start_time_i);
        cyc_d = TW'(cycle_time_i);
        id_d  = timer_id_i;
      end

      // pick the first expiry and pop a timer id, or refuse a zero time or an empty pool
      dlts_pkg::OP_CREATE: begin
        if (sel_time == '0) begin
          rvalid_d = 1'b1;
          res_d = '{kind: dlts_pkg::KIND_CREATE, rid: '0,
                    status: dlts_pkg::STS_ZERO_TIME, last: 1'b1};
        end else if (free_act_q == Nil) begin
          rvalid_d = 1'b1;
          res_d = '{kind: dlts_pkg::KIND_CREATE, rid: '0,
                    status: dlts_pkg::STS_NO_FREE, last: 1'b1};
        end else begin
          a_d = free_act_q;
          free_act_d = fa_link;
          act_period_d[fa_i] = cyc_q;
          dt_d = sel_time;
        end
      end

      // insert: empty list makes a new head, else start the walk
      dlts_pkg::OP_INS_START: begin
        act_link_d[a_i] = Nil;
        if (head_q == Nil) begin
          free_slot_d = fs_link;
          slot_delta_d[fs_i] = dt_q;
          slot_first_d[fs_i] = a_i;
          slot_last_d[fs_i]  = a_i;
          slot_link_d[fs_i]  = Nil;
          head_d = free_slot_q;
          countdown_d = dt_q;
        end else begin
          tx_d  = head_q;
          dtx_d = countdown_q;
        end
      end

      // insert: step on, join the slot, or put a new slot in front of the head
      dlts_pkg::OP_INS_WALK: begin
        if (dt_q > dtx_q) begin
          nx_d = tx_link;
        end else if (dt_q == dtx_q) begin
          act_link_d[slot_last_q[tx_i]] = a_q;
          slot_last_d[tx_i] = a_i;
        end else begin
          free_slot_d = fs_link;
          slot_delta_d[fs_i] = dt_q;
          slot_first_d[fs_i] = a_i;
          slot_last_d[fs_i]  = a_i;
          slot_link_d[fs_i]  = tx_q;
          slot_delta_d[tx_i] = dtx_q - dt_q;
          head_d = free_slot_q;
          countdown_d = dt_q;
        end
      end

      // insert: append at the tail, split before the next slot, or move on
      dlts_pkg::OP_INS_NEXT: begin
        if (nx_q == Nil) begin
          free_slot_d = fs_link;
          slot_delta_d[fs_i] = dt_q - dtx_q;
          slot_first_d[fs_i] = a_i;
          slot_last_d[fs_i]  = a_i;
          slot_link_d[fs_i]  = Nil;
          slot_link_d[tx_i]  = free_slot_q;
        end else if (dt_q < walk_sum) begin
          free_slot_d = fs_link;
          slot_delta_d[fs_i] = dt_q - dtx_q;
          slot_first_d[fs_i] = a_i;
          slot_last_d[fs_i]  = a_i;
          slot_link_d[fs_i]  = nx_q;
          slot_link_d[tx_i]  = free_slot_q;
          slot_delta_d[nx_i] = walk_sum - dt_q;
        end else begin
          tx_d  = nx_q;
          dtx_d = walk_sum;
        end
      end

      dlts_pkg::OP_C_EMIT: begin
        rvalid_d = 1'b1;
        res_d = '{kind: dlts_pkg::KIND_CREATE, rid: dlts_pkg::RID_W'(a_q),
                  status: dlts_pkg::STS_OK, last: 1'b1};
      end

      // delete: range and empty-list check, then start at the head slot
      dlts_pkg::OP_DEL_CHECK: begin
        if (32'(id_q) >= 32'(avail_q)) begin
          rvalid_d = 1'b1;
          res_d = '{kind: dlts_pkg::KIND_DELETE, rid: '0,
                    status: dlts_pkg::STS_RANGE, last: 1'b1};
        end else if (head_q == Nil) begin
          rvalid_d = 1'b1;
          res_d = '{kind: dlts_pkg::KIND_DELETE, rid: dlts_pkg::RID_W'(id_q),
                    status: dlts_pkg::STS_NOT_FOUND, last: 1'b1};
        end else begin
          s_d    = head_q;
          ps_d   = Nil;
          a_d    = LW'(slot_first_q[head_i]);
          prev_d = Nil;
        end
      end

      // delete: one timer id or one slot hop per cycle
      dlts_pkg::OP_DEL_WALK: begin
        if (a_q == Nil) begin
          if (s_link == Nil) begin
            rvalid_d = 1'b1;
            res_d = '{kind: dlts_pkg::KIND_DELETE, rid: dlts_pkg::RID_W'(id_q),
                      status: dlts_pkg::STS_NOT_FOUND, last: 1'b1};
          end else begin
            ps_d   = s_q;
            s_d    = s_link;
            a_d    = LW'(slot_first_q[s_link[IW-1:0]]);
            prev_d = Nil;
          end
        end else if (id_hit) begin
          if (prev_q == Nil) begin
            slot_first_d[s_i] = (a_link != Nil) ? a_link[IW-1:0] : '0;
          end else begin
            act_link_d[prev_i] = a_link;
            if (slot_last_q[s_i] == a_i) begin
              slot_last_d[s_i] = prev_i;
            end
          end
          act_period_d[a_i] = '0;
          act_link_d[a_i]   = free_act_q;
          free_act_d        = a_q;
          if (!(prev_q == Nil && a_link == Nil)) begin
            rvalid_d = 1'b1;
            res_d = '{kind: dlts_pkg::KIND_DELETE, rid: dlts_pkg::RID_W'(id_q),
                      status: dlts_pkg::STS_OK, last: 1'b1};
          end
        end else begin
          prev_d = a_q;
          a_d    = a_link;
        end
      end

      // emptied slot: fetch its successor and the delta to carry over
      dlts_pkg::OP_DEL_REM: begin
        nx_d  = s_link;
        tmp_d = (s_q == head_q) ? countdown_q : slot_delta_q[s_i];
      end

      // merge the delta into the successor and free the slot
      dlts_pkg::OP_DEL_REM2: begin
        if (nx_q != Nil) begin
          slot_delta_d[nx_i] = rem_sum;
        end
        if (s_q == head_q) begin
          head_d = nx_q;
          countdown_d = (nx_q == Nil) ? '0 : rem_sum;
        end else begin
          slot_link_d[ps_i] = nx_q;
        end
        slot_delta_d[s_i] = '0;
        slot_link_d[s_i]  = free_slot_q;
        free_slot_d       = s_q;
        rvalid_d = 1'b1;
        res_d = '{kind: dlts_pkg::KIND_DELETE, rid: dlts_pkg::RID_W'(id_q),
                  status: dlts_pkg::STS_OK, last: 1'b1};
      end

      // count down; on expiry pop the head slot
      dlts_pkg::OP_TICK: begin
        if (countdown_q != '0) begin
          countdown_d = countdown_q - TW'(1);
          if (countdown_q == TW'(1) && head_q != Nil) begin
            head_d = head_link;
            countdown_d = (head_link == Nil) ? '0 : nh_delta;
            a_d = LW'(slot_first_q[head_i]);
            slot_delta_d[head_i] = '0;
            slot_link_d[head_i]  = free_slot_q;
            free_slot_d          = head_q;
          end
        end
      end

      // expired id: free a one-shot id, hand a periodic id to insert
      dlts_pkg::OP_T_ACT: begin
        chain_d = a_link;
        if (a_period == '0) begin
          act_period_d[a_i] = '0;
          act_link_d[a_i]   = free_act_q;
          free_act_d        = a_q;
          rvalid_d = 1'b1;
          res_d = '{kind: dlts_pkg::KIND_EXPIRE, rid: dlts_pkg::RID_W'(a_q),
                    status: dlts_pkg::STS_OK, last: (a_link == Nil)};
          if (a_link != Nil) begin
            a_d = a_link;
          end
        end else begin
          act_link_d[a_i] = Nil;
          dt_d = a_period;
        end
      end

      // report a re-inserted id and move along the chain
      dlts_pkg::OP_T_EMIT: begin
        rvalid_d = 1'b1;
        res_d = '{kind: dlts_pkg::KIND_EXPIRE, rid: dlts_pkg::RID_W'(a_q),
                  status: dlts_pkg::STS_OK, last: (chain_q == Nil)};
        a_d = chain_q;
      end

      default: ;
    endcase

    // register write: drop every timer and refill both free stacks
    if (cfg_we_i) begin
      avail_d     = cfg_avail;
      head_d      = Nil;
      countdown_d = '0;
      free_slot_d = (cfg_avail != '0) ? '0 : Nil;
      free_act_d  = (cfg_avail != '0) ? '0 : Nil;
      for (int i = 0; i < TimerCount; i++) begin
        slot_link_d[i]  = (i + 1 < int'(cfg_avail)) ? LW'(i + 1) : Nil;
        act_link_d[i]   = (i + 1 < int'(cfg_avail)) ? LW'(i + 1) : Nil;
        act_period_d[i] = '0;
      end
    end
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= Nil;
      free_slot_q <= (AvailRst > 0) ? '0 : Nil;
      free_act_q  <= (AvailRst > 0) ? '0 : Nil;
      avail_q     <= LW'(AvailRst);
      countdown_q <= '0;
      rvalid_q    <= 1'b0;
      for (int i = 0; i < TimerCount; i++) begin
        slot_link_q[i]  <= (i + 1 < AvailRst) ? LW'(i + 1) : Nil;
        act_link_q[i]   <= (i + 1 < AvailRst) ? LW'(i + 1) : Nil;
        act_period_q[i] <= '0;
      end
    end else begin
      head_q       <= head_d;
      free_slot_q  <= free_slot_d;
      free_act_q   <= free_act_d;
      avail_q      <= avail_d;
      countdown_q  <= countdown_d;
      rvalid_q     <= rvalid_d;
      slot_link_q  <= slot_link_d;
      act_link_q   <= act_link_d;
      act_period_q <= act_period_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_delta_q <= slot_delta_d;
    slot_first_q <= slot_first_d;
    slot_last_q  <= slot_last_d;
    st_q    <= st_d;
    cyc_q   <= cyc_d;
    dt_q    <= dt_d;
    dtx_q   <= dtx_d;
    tmp_q   <= tmp_d;
    id_q    <= id_d;
    tx_q    <= tx_d;
    nx_q    <= nx_d;
    a_q     <= a_d;
    prev_q  <= prev_d;
    s_q     <= s_d;
    ps_q    <= ps_d;
    chain_q <= chain_d;
    res_q   <= res_d;
  end

  assign result_valid_o = rvalid_q;
  assign res_o          = res_q;

  // create and delete replies are single beats
  a_single_reply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && res_q.kind != dlts_pkg::KIND_EXPIRE) |-> res_q.last)
    else $error("reply beat without last");

  // refill leaves both free stacks at the same top
  a_refill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (free_slot_q == free_act_q))
    else $error("free stacks differ after register write");

  // a delete reply comes only out of a delete step
  a_del_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rvalid_q && res_q.kind == dlts_pkg::KIND_DELETE) |->
      ($past(op_i) == dlts_pkg::OP_DEL_CHECK || $past(op_i) == dlts_pkg::OP_DEL_WALK ||
       $past(op_i) == dlts_pkg::OP_DEL_REM2))
    else $error("delete reply without delete step");

endmodule

// ===== sv/delta_list_timer_scheduler_unit.sv =====
// Delta-list timer scheduler, top level.
// Joins the sequencer and the datapath; depends on dlts_pkg, dlts_ctrl, dlts_datapath.
//
// Usage:
//   An item (action, start_time, cycle_time, timer_id) is taken at a rising edge with
//   start high and busy low. Results leave as one-cycle beats on result_valid_o with
//   kind_o, result_id_o, status_o and last_o; the receiver cannot stall them, so each
//   beat must be taken in its cycle. last_o marks the final beat of an item.
//   A create answers from the create check when it is refused, else after its insert:
//   into an empty list the insert makes a new head at once, else it walks the slots
//   in order until the timer joins a slot, lands before one or lands behind the last.
//   Delete answers from its range check on a range error or an empty list, else after
//   a walk over timer ids and slot hops, plus the unlink steps when it empties a slot.
//   A tick with no expiry gives no beat; an expiry gives one beat per expired id, from
//   the expiry step for a one-shot id and after an insert walk for a periodic id.
//   These walks set the rate: no new item is taken until busy is low again.
//   The register timers_in_use is written with cfg_we_i and cfg_wdata_i while busy is
//   low by the user, unchecked by the block; a write drops all timers, refills free stacks.
//   Reset leaves 16 timer ids (or the pool size, if smaller) free and no timer running.
module delta_list_timer_scheduler_unit #(
  parameter int TimerCount = dlts_pkg::TIMER_COUNT_DEF,
  parameter int TimeBits   = dlts_pkg::TIME_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [dlts_pkg::ACT_W-1:0]  action_i,
  input  logic [dlts_pkg::TIN_W-1:0]  start_time_i,
  input  logic [dlts_pkg::TIN_W-1:0]  cycle_time_i,
  input  logic [dlts_pkg::ID_W-1:0]   timer_id_i,
  input  logic                        cfg_we_i,
  input  logic [dlts_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                        result_valid_o,
  output logic [1:0]                  kind_o,
  output logic [dlts_pkg::RID_W-1:0]  result_id_o,
  output logic [dlts_pkg::STS_W-1:0]  status_o,
  output logic                        last_o
);

  dlts_pkg::op_e   op;
  dlts_pkg::stat_t stat;
  dlts_pkg::res_t  res;

  // sequencer
  dlts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .stat_i   (stat),
    .op_o     (op),
    .busy     (busy)
  );

  // tables and arithmetic
  dlts_datapath #(
    .TimerCount (TimerCount),
    .TimeBits   (TimeBits)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .start_time_i   (start_time_i),
    .cycle_time_i   (cycle_time_i),
    .timer_id_i     (timer_id_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .res_o          (res)
  );

  // result beat fields
  assign kind_o      = res.kind;
  assign result_id_o = res.rid;
  assign status_o    = res.status;
  assign last_o      = res.last;

endmodule
